/* src/vdts_pkg.sv */
// Shared types, sizes and register indexes of the voxel density sampler.
`default_nettype none
package vdts_pkg;

	localparam int GRID_X_MAX = 32;
	localparam int GRID_Y_MAX = 32;
	localparam int GRID_Z_MAX = 32;

	localparam int STORE_DEPTH = GRID_X_MAX * GRID_Y_MAX * GRID_Z_MAX;
	localparam int AW   = $clog2(STORE_DEPTH);
	localparam int XW   = $clog2(GRID_X_MAX);
	localparam int YW   = $clog2(GRID_Y_MAX);
	localparam int ZW   = $clog2(GRID_Z_MAX);
	localparam int EXW  = $clog2(GRID_X_MAX + 1);
	localparam int EYW  = $clog2(GRID_Y_MAX + 1);
	localparam int EZW  = $clog2(GRID_Z_MAX + 1);
	localparam int EXYW = $clog2(GRID_X_MAX * GRID_Y_MAX + 1);

	localparam int CFG_IW = 3;
	localparam int CFG_DW = 24;

	localparam logic [CFG_IW-1:0] CFG_GRID_X  = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_GRID_Y  = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_GRID_Z  = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_INV_VOX = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_DEFAULT = 3'd4;

	localparam logic ACT_WRITE  = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	typedef struct packed {
		logic               action;
		logic signed [31:0] coord_x;
		logic signed [31:0] coord_y;
		logic signed [31:0] coord_z;
		logic [15:0]        density_in;
	} vdts_in_t;

	typedef struct packed {
		logic [15:0] density_out;
		logic        outside;
	} vdts_out_t;

endpackage
`default_nettype wire

/* src/voxel_density_trilinear_sampler.sv */
// Top level of the voxel density sampler: configuration, sequencer and datapath.
`default_nettype none
// The block holds a grid of Q8.8 densities in one single-port RAM and handles
// one item at a time. An item is taken when start is high and busy is low; its
// one result shows on result for exactly one cycle with done high, and the
// receiver must take it then. A write item runs an index check and then the
// store write, and ends after the check when the index falls outside the grid.
// A sample whose base cell is outside the grid ends after the scalings. An
// in-grid sample does the three position scalings on one shared multiplier,
// the eight corner reads from the single RAM port, the weighting passes along
// y and z and the final rounding. The done strobe rises in the same cycle in
// which busy falls. The user must write configuration only while busy is low;
// the block itself does not enforce it. The store is not cleared by reset; a
// voxel must be written before a sample reads it.
module voxel_density_trilinear_sampler import vdts_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire vdts_in_t          item,
	output logic                   done,
	output vdts_out_t              result,
	input  wire logic              cfg_we,
	input  wire logic [CFG_IW-1:0] cfg_index,
	input  wire logic [CFG_DW-1:0] cfg_wdata
);

	typedef enum logic [3:0] {
		S_IDLE, S_WCHK, S_WR, S_MUL, S_RD, S_DAT, S_MY, S_MZ, S_FIN
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [5:0]  gx_q, gy_q, gz_q;
	logic [23:0] inv_q;
	logic [15:0] dflt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gx_q   <= 6'd32;
			gy_q   <= 6'd32;
			gz_q   <= 6'd32;
			inv_q  <= 24'd65536;
			dflt_q <= 16'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GRID_X:  gx_q   <= cfg_wdata[5:0];
				CFG_GRID_Y:  gy_q   <= cfg_wdata[5:0];
				CFG_GRID_Z:  gz_q   <= cfg_wdata[5:0];
				CFG_INV_VOX: inv_q  <= cfg_wdata;
				CFG_DEFAULT: dflt_q <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// Effective grid sizes saturate at the store's dimensions.
	logic [EXW-1:0]  ex;
	logic [EYW-1:0]  ey;
	logic [EZW-1:0]  ez;
	logic [EXYW-1:0] exy_q;

	assign ex = (32'(gx_q) > 32'(GRID_X_MAX)) ? EXW'(GRID_X_MAX) : EXW'(gx_q);
	assign ey = (32'(gy_q) > 32'(GRID_Y_MAX)) ? EYW'(GRID_Y_MAX) : EYW'(gy_q);
	assign ez = (32'(gz_q) > 32'(GRID_Z_MAX)) ? EZW'(GRID_Z_MAX) : EZW'(gz_q);

	always_ff @(posedge clk) begin
		exy_q <= EXYW'(32'(ex) * 32'(ey));
	end

	// Datapath registers.
	vdts_in_t        item_q;
	logic [1:0]      cnt_q;
	logic [2:0]      corner_q;
	logic            out_acc_q;
	logic [XW-1:0]   ix_q;
	logic [YW-1:0]   iy_q;
	logic [ZW-1:0]   iz_q;
	logic [15:0]     fx_q, fy_q, fz_q;
	logic [56:0]     prod_s1;
	logic            beyond_q;
	logic [32:0]     sx_q;
	logic [48:0]     sy_q;
	logic [63:0]     acc_q;

	logic accept;
	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);

	// Scaling: one axis enters the multiplier per cycle, the previous one is
	// checked against the grid.
	logic signed [31:0] mul_coord;
	logic [1:0]         axis_e;
	logic [23:0]        p_hi;
	logic [23:0]        p_lim;
	logic               axis_bad;

	always_comb begin
		case (cnt_q)
			2'd0:    mul_coord = item_q.coord_x;
			2'd1:    mul_coord = item_q.coord_y;
			default: mul_coord = item_q.coord_z;
		endcase
		axis_e = cnt_q - 2'd1;
		p_hi   = prod_s1[55:32];
		case (axis_e)
			2'd0:    p_lim = 24'(ex);
			2'd1:    p_lim = 24'(ey);
			default: p_lim = 24'(ez);
		endcase
		axis_bad = prod_s1[56] || (p_hi >= p_lim);
	end

	// Write index check.
	logic wr_bad;
	assign wr_bad = item_q.coord_x[31] || (item_q.coord_x[30:0] >= 31'(ex)) ||
		item_q.coord_y[31] || (item_q.coord_y[30:0] >= 31'(ey)) ||
		item_q.coord_z[31] || (item_q.coord_z[30:0] >= 31'(ez));

	// Corner address and beyond-grid test.
	logic [XW:0]   xa;
	logic [YW:0]   ya;
	logic [ZW:0]   za;
	logic          beyond;
	logic [AW-1:0] ram_addr;

	assign xa = {1'b0, ix_q} + (XW+1)'(corner_q[0]);
	assign ya = {1'b0, iy_q} + (YW+1)'(corner_q[1]);
	assign za = {1'b0, iz_q} + (ZW+1)'(corner_q[2]);
	assign beyond = (32'(xa) >= 32'(ex)) || (32'(ya) >= 32'(ey)) || (32'(za) >= 32'(ez));
	assign ram_addr = AW'(32'(xa) + 32'(ya) * 32'(ex) + 32'(za) * 32'(exy_q));

	logic        ram_we;
	logic [15:0] ram_rdata;
	assign ram_we = (state_q == S_WR);

	vdts_ram #(.WIDTH(16), .DEPTH(STORE_DEPTH)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (item_q.density_in),
		.rdata (ram_rdata)
	);

	// Corner weights and blending.
	logic [16:0] wx, wy, wz;
	logic [15:0] corner_d;
	logic [64:0] rnd;

	assign wx = corner_q[0] ? {1'b0, fx_q} : 17'h10000 - {1'b0, fx_q};
	assign wy = corner_q[1] ? {1'b0, fy_q} : 17'h10000 - {1'b0, fy_q};
	assign wz = corner_q[2] ? {1'b0, fz_q} : 17'h10000 - {1'b0, fz_q};
	assign corner_d = beyond_q ? dflt_q : ram_rdata;
	assign rnd = {1'b0, acc_q} + (65'd1 << 47);

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q    <= item;
			out_acc_q <= 1'b0;
		end
		case (state_q)
			S_WCHK: begin
				ix_q <= item_q.coord_x[XW-1:0];
				iy_q <= item_q.coord_y[YW-1:0];
				iz_q <= item_q.coord_z[ZW-1:0];
			end
			S_MUL: begin
				prod_s1 <= 57'(mul_coord) * 57'($signed({1'b0, inv_q}));
				if (cnt_q != 2'd0) begin
					out_acc_q <= out_acc_q | axis_bad;
					case (axis_e)
						2'd0: begin
							ix_q <= p_hi[XW-1:0];
							fx_q <= prod_s1[31:16];
						end
						2'd1: begin
							iy_q <= p_hi[YW-1:0];
							fy_q <= prod_s1[31:16];
						end
						default: begin
							iz_q <= p_hi[ZW-1:0];
							fz_q <= prod_s1[31:16];
						end
					endcase
				end
			end
			S_RD:  beyond_q <= beyond;
			S_DAT: sx_q <= (corner_q[0] ? sx_q : 33'd0) + 33'(wx) * 33'(corner_d);
			S_MY:  sy_q <= (corner_q[1] ? sy_q : 49'd0) + 49'(wy) * 49'(sx_q);
			S_MZ:  acc_q <= (corner_q[2] ? acc_q : 64'd0) + 64'(wz) * 64'(sy_q);
			default: ;
		endcase
	end

	// Sequencer with the registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= 2'd0;
			corner_q <= 3'd0;
			done     <= 1'b0;
			result   <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					cnt_q    <= 2'd0;
					corner_q <= 3'd0;
					if (accept) begin
						state_q <= (item.action == ACT_WRITE) ? S_WCHK : S_MUL;
					end
				end
				S_WCHK: begin
					if (wr_bad) begin
						result  <= '{density_out: item_q.density_in, outside: 1'b1};
						done    <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_WR;
					end
				end
				S_WR: begin
					result  <= '{density_out: item_q.density_in, outside: 1'b0};
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				S_MUL: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						if (out_acc_q || axis_bad) begin
							result  <= '{density_out: dflt_q, outside: 1'b1};
							done    <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: state_q <= S_DAT;
				S_DAT: begin
					if (corner_q[0]) begin
						state_q <= S_MY;
					end else begin
						corner_q <= corner_q + 3'd1;
						state_q  <= S_RD;
					end
				end
				S_MY: begin
					if (corner_q[1]) begin
						state_q <= S_MZ;
					end else begin
						corner_q <= corner_q + 3'd1;
						state_q  <= S_RD;
					end
				end
				S_MZ: begin
					if (corner_q[2]) begin
						state_q <= S_FIN;
					end else begin
						corner_q <= corner_q + 3'd1;
						state_q  <= S_RD;
					end
				end
				S_FIN: begin
					result  <= '{density_out: (rnd[64:48] > 17'h0FFFF) ? 16'hFFFF : rnd[63:48],
						outside: 1'b0};
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	// A result only ever follows an item that was in progress.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without an item in progress");

	// The idle state lies between any two results, so they never come back to back.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two result strobes in a row");

	// The store is written only for an index that passed the grid check.
	a_write_checked: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ($past(state_q) == S_WCHK) && !done)
		else $error("store write without a passed index check");
`endif

endmodule
`default_nettype wire

/* src/vdts_ram.sv */
// Generic single-port synchronous RAM with a registered read.
`default_nettype none
module vdts_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule
`default_nettype wire

/* sim/tb_voxel_density_trilinear_sampler.sv */
// Self-checking testbench of the voxel density trilinear sampler.
`timescale 1ns / 100ps
`default_nettype none
module tb_voxel_density_trilinear_sampler;
	import vdts_pkg::*;

	// The clock runs at 12 ns. Stimulus changes on the falling edge and the
	// result port is sampled on the rising edge, so nothing depends on the
	// order of events inside one time step.
	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	vdts_in_t          item_drv = '0;
	logic              done;
	vdts_out_t         result;
	logic              cfg_we = 1'b0;
	logic [CFG_IW-1:0] cfg_index = CFG_GRID_X;
	logic [CFG_DW-1:0] cfg_wdata = '0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	voxel_density_trilinear_sampler i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item_drv),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// Shadow copy of the configuration, as the block should hold it.
	logic [5:0]  grid_x_reg = 6'd32;
	logic [5:0]  grid_y_reg = 6'd32;
	logic [5:0]  grid_z_reg = 6'd32;
	logic [23:0] inv_voxel_reg = 24'd65536;
	logic [15:0] default_reg = 16'd0;

	// Shadow copy of the density store, with a flag for every entry that has
	// been written. Samples are kept away from entries that were never written.
	logic [15:0] voxel_mem [STORE_DEPTH];
	bit          voxel_written [STORE_DEPTH];

	vdts_out_t pending_results [$];
	int        mismatch_count = 0;
	int        idle_pct = 0;

	// Fill box: a small region of written voxels that the aimed samples target.
	int box_org [3];
	int box_len [3];

	function automatic int eff_size(input logic [5:0] r, input int maxv);
		return (r > maxv) ? maxv : int'(r);
	endfunction

	function automatic int axis_limit(input int k);
		case (k)
			0: return eff_size(grid_x_reg, GRID_X_MAX);
			1: return eff_size(grid_y_reg, GRID_Y_MAX);
			default: return eff_size(grid_z_reg, GRID_Z_MAX);
		endcase
	endfunction

	function automatic int voxel_addr(input int x, input int y, input int z);
		return x + y * axis_limit(0) + z * axis_limit(0) * axis_limit(1);
	endfunction

	// Scales one world coordinate into cell index and 16-bit fraction.
	// Returns 1 when the base cell falls outside the grid on this axis.
	function automatic bit scale_axis(input logic signed [31:0] c, input int k,
			output int idx, output int frac);
		longint p;
		p = longint'(c) * longint'({8'd0, inv_voxel_reg});
		idx = 0;
		frac = 0;
		if (p < 0) return 1'b1;
		if ((p >>> 32) >= axis_limit(k)) return 1'b1;
		idx = int'(p >>> 32);
		frac = int'((p >> 16) & 64'hFFFF);
		return 1'b0;
	endfunction

	function automatic logic signed [31:0] coord_of(input vdts_in_t it, input int k);
		case (k)
			0: return it.coord_x;
			1: return it.coord_y;
			default: return it.coord_z;
		endcase
	endfunction

	// True when a sample would read a corner entry that was never written.
	function automatic bit reads_unwritten(input vdts_in_t it);
		int idx [3];
		int frac [3];
		bit out_flag;
		out_flag = 1'b0;
		if (it.action == ACT_WRITE) return 1'b0;
		for (int k = 0; k < 3; k++)
			out_flag |= scale_axis(coord_of(it, k), k, idx[k], frac[k]);
		if (out_flag) return 1'b0;
		for (int cz = 0; cz < 2; cz++)
			for (int cy = 0; cy < 2; cy++)
				for (int cx = 0; cx < 2; cx++)
					if (idx[0] + cx < axis_limit(0) && idx[1] + cy < axis_limit(1) &&
							idx[2] + cz < axis_limit(2) &&
							!voxel_written[voxel_addr(idx[0] + cx, idx[1] + cy, idx[2] + cz)])
						return 1'b1;
		return 1'b0;
	endfunction

	// Works out the result of one item and applies a write to the shadow store.
	function automatic vdts_out_t predict_density(input vdts_in_t it);
		vdts_out_t res;
		int idx [3];
		int frac [3];
		logic [65:0] acc;
		longint unsigned wx, wy, wz, w;
		logic [15:0] d;
		logic signed [31:0] c;
		bit out_flag;
		out_flag = 1'b0;
		res = '0;
		if (it.action == ACT_WRITE) begin
			for (int k = 0; k < 3; k++) begin
				c = coord_of(it, k);
				if (c < 0 || c >= axis_limit(k)) out_flag = 1'b1;
				else idx[k] = int'(c);
			end
			if (!out_flag) begin
				voxel_mem[voxel_addr(idx[0], idx[1], idx[2])] = it.density_in;
				voxel_written[voxel_addr(idx[0], idx[1], idx[2])] = 1'b1;
			end
			res.density_out = it.density_in;
			res.outside = out_flag;
			return res;
		end
		for (int k = 0; k < 3; k++)
			out_flag |= scale_axis(coord_of(it, k), k, idx[k], frac[k]);
		if (out_flag) begin
			res.density_out = default_reg;
			res.outside = 1'b1;
			return res;
		end
		acc = '0;
		for (int cz = 0; cz < 2; cz++) begin
			wz = cz ? frac[2] : 65536 - frac[2];
			for (int cy = 0; cy < 2; cy++) begin
				wy = cy ? frac[1] : 65536 - frac[1];
				for (int cx = 0; cx < 2; cx++) begin
					wx = cx ? frac[0] : 65536 - frac[0];
					w = wx * wy * wz;
					// A high corner that reaches the grid size reads the default.
					if (idx[0] + cx >= axis_limit(0) || idx[1] + cy >= axis_limit(1) ||
							idx[2] + cz >= axis_limit(2))
						d = default_reg;
					else
						d = voxel_mem[voxel_addr(idx[0] + cx, idx[1] + cy, idx[2] + cz)];
					acc = acc + 66'(w) * 66'(d);
				end
			end
		end
		acc = (acc + (66'd1 << 47)) >> 48;
		res.density_out = (acc > 66'hFFFF) ? 16'hFFFF : acc[15:0];
		res.outside = 1'b0;
		return res;
	endfunction

	// Every done strobe is checked against the oldest pending result.
	always @(posedge clk) begin
		vdts_out_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("ERROR: result %0h/%0b with none pending",
						result.density_out, result.outside);
			end else begin
				want = pending_results.pop_front();
				if (result.density_out !== want.density_out || result.outside !== want.outside) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("ERROR: density exp %0h got %0h, outside exp %0b got %0b",
							want.density_out, result.density_out, want.outside, result.outside);
				end
			end
		end
	end

	// Presents one item and holds it until the block takes it. The start line
	// stays high afterwards so that items can follow back to back.
	task automatic send_item(input vdts_in_t it);
		vdts_out_t expected;
		@(negedge clk);
		item_drv = it;
		start = 1'b1;
		do @(posedge clk); while (busy);
		expected = predict_density(it);
		pending_results = {pending_results, expected};
	endtask

	// Sender gap with the probability of the current idling phase.
	task automatic maybe_idle();
		if ($urandom_range(0, 99) < idle_pct) begin
			@(negedge clk);
			start = 1'b0;
			repeat ($urandom_range(0, 6)) @(posedge clk);
		end
	endtask

	// Holds off the sender until every pending result has come, then lets
	// the block settle.
	task automatic wait_all_results();
		int guard;
		guard = 0;
		@(negedge clk);
		start = 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
			guard++;
			if (guard > 100000) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(posedge clk);
		case (idx)
			CFG_GRID_X:  grid_x_reg = val[5:0];
			CFG_GRID_Y:  grid_y_reg = val[5:0];
			CFG_GRID_Z:  grid_z_reg = val[5:0];
			CFG_INV_VOX: inv_voxel_reg = val[23:0];
			CFG_DEFAULT: default_reg = val[15:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic vdts_in_t make_item(input logic act, input int x, input int y,
			input int z, input logic [15:0] d);
		vdts_in_t it;
		it.action = act;
		it.coord_x = x;
		it.coord_y = y;
		it.coord_z = z;
		it.density_in = d;
		return it;
	endfunction

	// Chooses a fill box inside the grid and writes random densities into it.
	task automatic fill_box(input bit at_far_corner);
		for (int k = 0; k < 3; k++) begin
			box_len[k] = (axis_limit(k) < 3) ? axis_limit(k) : 3;
			if (box_len[k] == 0) box_org[k] = 0;
			else if (at_far_corner) box_org[k] = axis_limit(k) - box_len[k];
			else box_org[k] = $urandom_range(0, axis_limit(k) - box_len[k]);
		end
		for (int z = 0; z < box_len[2]; z++)
			for (int y = 0; y < box_len[1]; y++)
				for (int x = 0; x < box_len[0]; x++) begin
					send_item(make_item(ACT_WRITE, box_org[0] + x, box_org[1] + y,
						box_org[2] + z, 16'($urandom)));
					maybe_idle();
				end
	endtask

	// New configuration, written while the block is idle, then a fresh box.
	task automatic set_config(input int gx, input int gy, input int gz, input int inv,
			input int dflt, input bit at_far_corner);
		wait_all_results();
		write_reg(CFG_GRID_X, CFG_DW'(gx));
		write_reg(CFG_GRID_Y, CFG_DW'(gy));
		write_reg(CFG_GRID_Z, CFG_DW'(gz));
		write_reg(CFG_INV_VOX, CFG_DW'(inv));
		write_reg(CFG_DEFAULT, CFG_DW'(dflt));
		fill_box(at_far_corner);
	endtask

	// A sample aimed into the fill box: the wanted scaled position is divided
	// by the reciprocal voxel size to get the world coordinate.
	function automatic vdts_in_t aimed_sample();
		vdts_in_t it;
		longint target;
		longint coord [3];
		for (int k = 0; k < 3; k++) begin
			target = (longint'(box_org[k] + $urandom_range(0, box_len[k] - 1)) << 32) |
				longint'($urandom & 32'hFFFF_FFFF);
			if (inv_voxel_reg == 0) coord[k] = $urandom;
			else coord[k] = target / longint'({8'd0, inv_voxel_reg}) +
				longint'($urandom_range(0, 1));
		end
		it = make_item(ACT_SAMPLE, int'(coord[0]), int'(coord[1]), int'(coord[2]),
			16'($urandom));
		return it;
	endfunction

	// Random item mix: mostly samples aimed at written voxels, some writes
	// into the box and some fully random noise.
	task automatic random_items(input int n);
		vdts_in_t it;
		int pick;
		bit box_ok;
		box_ok = box_len[0] > 0 && box_len[1] > 0 && box_len[2] > 0;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (box_ok && pick < 65) begin
				it = aimed_sample();
			end else if (box_ok && pick < 80) begin
				it = make_item(ACT_WRITE, box_org[0] + $urandom_range(0, box_len[0] - 1),
					box_org[1] + $urandom_range(0, box_len[1] - 1),
					box_org[2] + $urandom_range(0, box_len[2] - 1), 16'($urandom));
			end else begin
				it = make_item(1'($urandom), $urandom, $urandom, $urandom, 16'($urandom));
			end
			// A sample that would touch a never-written voxel becomes a write.
			if (reads_unwritten(it)) it.action = ACT_WRITE;
			send_item(it);
			maybe_idle();
		end
	endtask

	// Sample at exact voxel and fraction values, given in Q16.16 at unit scale.
	task automatic sample_at(input int x, input int y, input int z);
		vdts_in_t it;
		it = make_item(ACT_SAMPLE, x, y, z, 16'hFFFF);
		if (reads_unwritten(it)) it.action = ACT_WRITE;
		send_item(it);
	endtask

	// Reset configuration: writes at the grid edges, extreme densities, and
	// samples on voxels, at maximum fraction, at the far corner where the high
	// corners read the default, and far outside the grid.
	task automatic test_directed_edges();
		idle_pct = 0;
		for (int z = 0; z < 2; z++)
			for (int y = 0; y < 2; y++)
				for (int x = 0; x < 2; x++)
					send_item(make_item(ACT_WRITE, x, y, z, (x + y + z) ? 16'hFFFF : 16'h0000));
		send_item(make_item(ACT_WRITE, 31, 31, 31, 16'h1234));
		send_item(make_item(ACT_WRITE, 32, 0, 0, 16'hFFFF));
		send_item(make_item(ACT_WRITE, -1, 0, 0, 16'h0001));
		send_item(make_item(ACT_WRITE, 0, 32'h7FFF_FFFF, 0, 16'h8000));
		send_item(make_item(ACT_WRITE, 0, 0, 32'h8000_0000, 16'h7FFF));
		sample_at(0, 0, 0);
		sample_at(32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF);
		sample_at(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
		sample_at(32'h001F_8000, 32'h001F_0000, 32'h001F_FFFF);
		sample_at(32'h0020_0000, 0, 0);
		sample_at(-1, 0, 0);
		sample_at(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		sample_at(32'h8000_0000, 0, 0);
		wait_all_results();
	endtask

	// Grid sizes of zero (everything outside), one, and above the maximum
	// (saturating), plus a zero reciprocal voxel size that pins every sample
	// to voxel zero.
	task automatic test_grid_extremes();
		set_config(0, 0, 0, 65536, 'hFFFF, 1'b0);
		random_items(20);
		set_config(1, 1, 1, 65536, 'h0000, 1'b0);
		random_items(20);
		set_config(63, 40, 33, 'hFFFFFF, 'h0100, 1'b1);
		random_items(30);
		set_config(4, 3, 2, 0, 'h5A5A, 1'b0);
		fill_box(1'b0);
		box_org = '{0, 0, 0};
		send_item(make_item(ACT_WRITE, 0, 0, 0, 16'h4321));
		random_items(20);
		set_config(32, 1, 32, 1, 'hFFFF, 1'b0);
		random_items(20);
	endtask

	// Random phases under changing configurations, with the idling percentage set
	// per phase; each new configuration waits until all results are in.
	task automatic test_random_phases();
		int pcts [4];
		pcts = '{0, 74, 74, 11};
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = pcts[ph];
			set_config($urandom_range(1, 32), $urandom_range(1, 32), $urandom_range(1, 32),
				65536, $urandom, 1'b0);
			random_items(80);
			set_config($urandom_range(2, 8), $urandom_range(2, 8), $urandom_range(2, 63),
				$urandom_range(4096, 1 << 20), $urandom, 1'($urandom_range(0, 1)));
			random_items(80);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (3) @(posedge clk);
		test_directed_edges();
		test_grid_extremes();
		test_random_phases();
		wait_all_results();
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Run limit, far above the slowest correct run.
	initial begin
		#(12 * 2000000);
		$display("FAILED: results differ");
		$finish;
	end

endmodule
`default_nettype wire
